// File: rtl/core/heat_cool_thermostat_lockout_assert.svh
// ----------------------------------------------------------------------------
// Thermostat lockout assertion macros
// Assertion helpers shared by the thermostat lockout RTL. Each macro expects
// clk and rst_n in scope and is empty when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef HEAT_COOL_THERMOSTAT_LOCKOUT_ASSERT_SVH
`define HEAT_COOL_THERMOSTAT_LOCKOUT_ASSERT_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge out of reset.
`define HTL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define HTL_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define HTL_ASSERT_ALWAYS(lbl, cond, msg)

`define HTL_ASSERT_IMPLY(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/core/htl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermostat lockout package
// Shared widths, codes and item layouts of the heat/cool thermostat block.
// ----------------------------------------------------------------------------
package htl_pkg;

  localparam int unsigned MS_PER_SECOND_DEF = 1000;

  localparam int unsigned IN_W       = 64;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TEMP_W     = 15;
  localparam int unsigned REM_W      = 16;
  // Milliseconds still to run on a lock, less one: below 2^31.
  localparam int unsigned WAIT_W     = 31;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_MANUAL      = 3'd1,
    REG_SETPOINT    = 3'd2,
    REG_HYST        = 3'd3,
    REG_HEAT_DELAY  = 3'd4,
    REG_COOL_DELAY  = 3'd5,
    REG_SEC_ENABLE  = 3'd6,
    REG_SEC_HYST    = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_AUTO   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    MAN_OFF  = 2'd0,
    MAN_HEAT = 2'd1,
    MAN_COOL = 2'd2
  } manual_t;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_HEAT      = 4'd1,
    ST_COOL      = 4'd2,
    ST_MAN_OFF   = 4'd3,
    ST_MAN_HEAT  = 4'd4,
    ST_MAN_COOL  = 4'd5,
    ST_LOCK_HEAT = 4'd6,
    ST_LOCK_COOL = 4'd7,
    ST_FAULT     = 4'd8
  } state_code_t;

  typedef enum logic [2:0] {
    CAUSE_RESET     = 3'd0,
    CAUSE_IN_BAND   = 3'd1,
    CAUSE_INACTIVE  = 3'd2,
    CAUSE_HEAT_LIM  = 3'd3,
    CAUSE_COOL_LIM  = 3'd4,
    CAUSE_OTHER     = 3'd5
  } cause_t;

  typedef struct packed {
    logic [1:0]               mode;
    logic [1:0]               manual;
    logic signed [TEMP_W-1:0] setpoint;
    logic [10:0]              hyst;
    logic [TIME_W-1:0]        heat_delay_ms;
    logic [TIME_W-1:0]        cool_delay_ms;
    logic                     sec_enable;
    logic [12:0]              sec_hyst;
  } cfg_regs_t;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic signed [TEMP_W-1:0] secondary_temp;
    logic                     secondary_valid;
    logic signed [TEMP_W-1:0] primary_temp;
    logic                     primary_valid;
    logic [TIME_W-1:0]        now_ms;
  } in_item_t;

  // Result item, last field in the lowest bits, padded to whole bytes.
  typedef struct packed {
    logic [2:0]       pad;
    logic             changed;
    logic [REM_W-1:0] lock_remaining_s;
    logic             auto_active;
    logic             cooling_demand;
    logic             heating_demand;
    logic             cooler_on;
    logic             heater_on;
    cause_t           idle_cause;
    state_code_t      state_code;
  } out_item_t;

  // Per-item outcome of the control stage, carried down the pipeline.
  typedef struct packed {
    state_code_t state;
    cause_t      cause;
    logic        heater;
    logic        cooler;
    logic        heat_dem;
    logic        cool_dem;
    logic        auto_act;
    logic        drive_chg;
    logic        rem_vld;
  } step_info_t;

endpackage

// File: rtl/core/heat_cool_thermostat_lockout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heat/cool thermostat with lockout
// Takes one temperature sample item per clock and returns one result item
// for each, passed through an input register, the control stage that updates
// the heater and cooler drives, the chamber limits and the lock ends, a
// reciprocal multiply that turns the lock time still to run into seconds,
// and the result register. The pipeline stalls only when the result register
// is full and not taken. The lockout delays are held in milliseconds, scaled
// by MS_PER_SECOND as they are written, and the configuration registers are
// meant to be written while no item is in flight.
// ----------------------------------------------------------------------------
module heat_cool_thermostat_lockout #(
  parameter int unsigned MS_PER_SECOND = htl_pkg::MS_PER_SECOND_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // now_ms[31:0], primary_valid[32], primary_temp[47:33],
  // secondary_valid[48], secondary_temp[63:49]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [htl_pkg::IN_W-1:0]       in_tdata,
  // state_code[3:0], idle_cause[6:4], heater_on[7], cooler_on[8],
  // heating_demand[9], cooling_demand[10], auto_active[11],
  // lock_remaining_s[27:12], changed[28], zero[31:29]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [htl_pkg::OUT_W-1:0]      out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [htl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htl_pkg::CFG_DATA_W-1:0] cfg_data
);

  htl_pkg::cfg_regs_t            cfg_regs;
  logic                          s1_valid, s1_ready;
  htl_pkg::step_info_t           s1_info;
  logic [htl_pkg::WAIT_W-1:0]    s1_wait;
  logic                          s2_valid, s2_ready;
  htl_pkg::step_info_t           s2_info;
  logic                          s2_sat;
  logic [htl_pkg::REM_W-1:0]     s2_quot;

  htl_cfg #(
    .MS_PER_SECOND (MS_PER_SECOND)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_regs  (cfg_regs)
  );

  htl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_regs  (cfg_regs),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_info   (s1_info),
    .s1_wait   (s1_wait)
  );

  htl_secs #(
    .MS_PER_SECOND (MS_PER_SECOND)
  ) u_secs (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_info  (s1_info),
    .s1_wait  (s1_wait),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_info  (s2_info),
    .s2_sat   (s2_sat),
    .s2_quot  (s2_quot)
  );

  htl_report u_report (
    .clk        (clk),
    .rst_n      (rst_n),
    .s2_valid   (s2_valid),
    .s2_ready   (s2_ready),
    .s2_info    (s2_info),
    .s2_sat     (s2_sat),
    .s2_quot    (s2_quot),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: rtl/core/htl_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermostat configuration registers
// Register file written through the configuration channel. Lockout delays
// are kept in milliseconds, converted as they are written.
// ----------------------------------------------------------------------------
module htl_cfg #(
  parameter int unsigned MS_PER_SECOND = htl_pkg::MS_PER_SECOND_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [htl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [htl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output htl_pkg::cfg_regs_t               cfg_regs
);

  localparam logic [htl_pkg::TIME_W-1:0] MS_K = htl_pkg::TIME_W'(MS_PER_SECOND);

  htl_pkg::cfg_regs_t regs_r;
  htl_pkg::cfg_regs_t regs_nxt;
  logic [htl_pkg::CFG_DATA_W+htl_pkg::TIME_W-1:0] delay_ms;

  assign cfg_ready = 1'b1;
  assign cfg_regs  = regs_r;

  // Delay times the tick rate, kept modulo 2^32.
  assign delay_ms = (htl_pkg::CFG_DATA_W+htl_pkg::TIME_W)'(cfg_data) *
                    (htl_pkg::CFG_DATA_W+htl_pkg::TIME_W)'(MS_K);

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index)
        htl_pkg::REG_MODE:       regs_nxt.mode          = cfg_data[1:0];
        htl_pkg::REG_MANUAL:     regs_nxt.manual        = cfg_data[1:0];
        htl_pkg::REG_SETPOINT:   regs_nxt.setpoint      = cfg_data[14:0];
        htl_pkg::REG_HYST:       regs_nxt.hyst          = cfg_data[10:0];
        htl_pkg::REG_HEAT_DELAY: regs_nxt.heat_delay_ms = delay_ms[htl_pkg::TIME_W-1:0];
        htl_pkg::REG_COOL_DELAY: regs_nxt.cool_delay_ms = delay_ms[htl_pkg::TIME_W-1:0];
        htl_pkg::REG_SEC_ENABLE: regs_nxt.sec_enable    = cfg_data[0];
        htl_pkg::REG_SEC_HYST:   regs_nxt.sec_hyst      = cfg_data[12:0];
        default:                 regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.mode          <= htl_pkg::MODE_OFF;
      regs_r.manual        <= htl_pkg::MAN_OFF;
      regs_r.setpoint      <= 15'sd2000;
      regs_r.hyst          <= 11'd50;
      regs_r.heat_delay_ms <= '0;
      regs_r.cool_delay_ms <= '0;
      regs_r.sec_enable    <= 1'b0;
      regs_r.sec_hyst      <= 13'd500;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// File: rtl/core/htl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermostat control stage
// Input register, then the mode, hysteresis, chamber limit and lockout logic
// that updates the drive state once per item and registers the outcome.
// ----------------------------------------------------------------------------
`include "heat_cool_thermostat_lockout_assert.svh"

module htl_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  htl_pkg::cfg_regs_t             cfg_regs,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [htl_pkg::IN_W-1:0]       in_tdata,
  output logic                           s1_valid,
  input  logic                           s1_ready,
  output htl_pkg::step_info_t            s1_info,
  output logic [htl_pkg::WAIT_W-1:0]     s1_wait
);

  logic                          s0_valid_r, s0_valid_nxt;
  logic [htl_pkg::IN_W-1:0]      s0_data_r;
  logic                          s1_valid_r, s1_valid_nxt;
  htl_pkg::step_info_t           s1_info_r, info_nxt;
  logic [htl_pkg::WAIT_W-1:0]    s1_wait_r, wait_nxt;
  logic                          s1_en, step;

  logic                          heater_r, heater_nxt;
  logic                          cooler_r, cooler_nxt;
  logic [htl_pkg::TIME_W-1:0]    heat_lock_r, heat_lock_nxt;
  logic [htl_pkg::TIME_W-1:0]    cool_lock_r, cool_lock_nxt;
  logic                          heat_lim_r, heat_lim_nxt;
  logic                          cool_lim_r, cool_lim_nxt;

  htl_pkg::in_item_t             item;

  // A lock is running when its end is set and lies less than 2^31 ms ahead.
  function automatic logic lock_active(input logic [31:0] lk_end, input logic [31:0] now);
    logic [31:0] d;
    d = lk_end - now;
    return (lk_end != '0) && (d != '0) && !d[31];
  endfunction

  function automatic logic later(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != '0) && !d[31];
  endfunction

  assign item      = htl_pkg::in_item_t'(s0_data_r);
  assign s1_en     = !s1_valid_r || s1_ready;
  assign in_tready = !s0_valid_r || s1_en;
  assign step      = s1_en && s0_valid_r;

  assign s1_valid  = s1_valid_r;
  assign s1_info   = s1_info_r;
  assign s1_wait   = s1_wait_r;

  assign s0_valid_nxt = in_tready ? in_tvalid : s0_valid_r;
  assign s1_valid_nxt = s1_en ? s0_valid_r : s1_valid_r;

  always_comb begin
    logic [31:0]        heat_end, cool_end, lk_end, d;
    logic               heat_busy, cool_busy;
    logic               want_h, want_c, want_o, rem_heat, rem_cool;
    logic               hd, cd;
    htl_pkg::state_code_t on_state;
    logic signed [16:0] pt_x, sp_x, hy_x;
    logic signed [18:0] sec_x, sec2_x, sp1_x, sp2_x, sh_x;

    heat_end  = item.now_ms + cfg_regs.heat_delay_ms;
    cool_end  = item.now_ms + cfg_regs.cool_delay_ms;
    heat_busy = lock_active(heat_lock_r, item.now_ms);
    cool_busy = lock_active(cool_lock_r, item.now_ms);

    pt_x   = {{2{item.primary_temp[14]}}, item.primary_temp};
    sp_x   = {{2{cfg_regs.setpoint[14]}}, cfg_regs.setpoint};
    hy_x   = {6'b0, cfg_regs.hyst};
    sec_x  = {{4{item.secondary_temp[14]}}, item.secondary_temp};
    sec2_x = {{3{item.secondary_temp[14]}}, item.secondary_temp, 1'b0};
    sp1_x  = {{4{cfg_regs.setpoint[14]}}, cfg_regs.setpoint};
    sp2_x  = {{3{cfg_regs.setpoint[14]}}, cfg_regs.setpoint, 1'b0};
    sh_x   = {6'b0, cfg_regs.sec_hyst};

    heater_nxt    = heater_r;
    cooler_nxt    = cooler_r;
    heat_lock_nxt = heat_lock_r;
    cool_lock_nxt = cool_lock_r;
    heat_lim_nxt  = heat_lim_r;
    cool_lim_nxt  = cool_lim_r;

    want_h   = 1'b0;
    want_c   = 1'b0;
    want_o   = 1'b0;
    rem_heat = 1'b0;
    rem_cool = 1'b0;
    hd       = 1'b0;
    cd       = 1'b0;
    on_state = htl_pkg::ST_IDLE;

    info_nxt          = '0;
    info_nxt.state    = htl_pkg::ST_IDLE;
    info_nxt.cause    = htl_pkg::CAUSE_OTHER;

    if (!item.primary_valid) begin
      heater_nxt     = 1'b0;
      cooler_nxt     = 1'b0;
      info_nxt.state = htl_pkg::ST_FAULT;
    end else if (cfg_regs.mode == htl_pkg::MODE_MANUAL) begin
      case (cfg_regs.manual)
        htl_pkg::MAN_HEAT: begin
          want_h   = 1'b1;
          on_state = htl_pkg::ST_MAN_HEAT;
        end
        htl_pkg::MAN_COOL: begin
          want_c   = 1'b1;
          on_state = htl_pkg::ST_MAN_COOL;
        end
        default: begin
          want_o         = 1'b1;
          info_nxt.state = htl_pkg::ST_MAN_OFF;
        end
      endcase
    end else if (cfg_regs.mode != htl_pkg::MODE_AUTO) begin
      want_o         = 1'b1;
      info_nxt.cause = htl_pkg::CAUSE_INACTIVE;
    end else begin
      info_nxt.auto_act = 1'b1;
      hd = (pt_x <= sp_x - hy_x);
      cd = !hd && (pt_x >= sp_x + hy_x);

      // Chamber limits latch beyond the band and release at half of it;
      // the release compare is done on doubled values.
      if (!cfg_regs.sec_enable || !item.secondary_valid) begin
        heat_lim_nxt = 1'b0;
        cool_lim_nxt = 1'b0;
      end else begin
        if (cool_lim_r) begin
          cool_lim_nxt = !(sec2_x > sp2_x - sh_x);
        end else begin
          cool_lim_nxt = (sec_x < sp1_x - sh_x);
        end
        if (heat_lim_r) begin
          heat_lim_nxt = !(sec2_x < sp2_x + sh_x);
        end else begin
          heat_lim_nxt = (sec_x > sp1_x + sh_x);
        end
      end

      if (hd && heat_lim_nxt) begin
        heater_nxt     = 1'b0;
        info_nxt.cause = htl_pkg::CAUSE_HEAT_LIM;
      end else if (cd && cool_lim_nxt) begin
        cooler_nxt     = 1'b0;
        info_nxt.cause = htl_pkg::CAUSE_COOL_LIM;
      end else if (hd) begin
        want_h   = 1'b1;
        on_state = htl_pkg::ST_HEAT;
      end else if (cd) begin
        want_c   = 1'b1;
        on_state = htl_pkg::ST_COOL;
      end else begin
        want_o         = 1'b1;
        info_nxt.cause = htl_pkg::CAUSE_IN_BAND;
      end
    end

    // A running heat lock holds off heating; a cooler that is still on is
    // dropped and may push the lock further out.
    if (want_h) begin
      if (heat_busy) begin
        if (cooler_r) begin
          cooler_nxt = 1'b0;
          if (later(heat_end, heat_lock_r)) begin
            heat_lock_nxt = heat_end;
          end
        end
        info_nxt.state = htl_pkg::ST_LOCK_HEAT;
        rem_heat       = 1'b1;
      end else begin
        if (!heater_r) begin
          heater_nxt    = 1'b1;
          cool_lock_nxt = cool_end;
        end
        cooler_nxt     = 1'b0;
        info_nxt.state = on_state;
      end
    end

    if (want_c) begin
      if (cool_busy) begin
        if (heater_r) begin
          heater_nxt = 1'b0;
          if (later(cool_end, cool_lock_r)) begin
            cool_lock_nxt = cool_end;
          end
        end
        info_nxt.state = htl_pkg::ST_LOCK_COOL;
        rem_cool       = 1'b1;
      end else begin
        if (!cooler_r) begin
          cooler_nxt    = 1'b1;
          heat_lock_nxt = heat_end;
        end
        heater_nxt     = 1'b0;
        info_nxt.state = on_state;
      end
    end

    if (want_o) begin
      if (heater_r) begin
        heater_nxt    = 1'b0;
        cool_lock_nxt = cool_end;
      end
      if (cooler_r) begin
        cooler_nxt    = 1'b0;
        heat_lock_nxt = heat_end;
      end
    end

    lk_end = rem_heat ? heat_lock_nxt : cool_lock_nxt;
    d      = lk_end - item.now_ms;
    info_nxt.rem_vld   = (rem_heat || rem_cool) && lock_active(lk_end, item.now_ms);
    wait_nxt           = d[htl_pkg::WAIT_W-1:0] - htl_pkg::WAIT_W'(1);

    info_nxt.heat_dem  = hd;
    info_nxt.cool_dem  = cd;
    info_nxt.heater    = heater_nxt;
    info_nxt.cooler    = cooler_nxt;
    info_nxt.drive_chg = (heater_nxt != heater_r) || (cooler_nxt != cooler_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      heater_r    <= 1'b0;
      cooler_r    <= 1'b0;
      heat_lock_r <= '0;
      cool_lock_r <= '0;
      heat_lim_r  <= 1'b0;
      cool_lim_r  <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (step) begin
        heater_r    <= heater_nxt;
        cooler_r    <= cooler_nxt;
        heat_lock_r <= heat_lock_nxt;
        cool_lock_r <= cool_lock_nxt;
        heat_lim_r  <= heat_lim_nxt;
        cool_lim_r  <= cool_lim_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_data_r <= in_tdata;
    end
    if (step) begin
      s1_info_r <= info_nxt;
      s1_wait_r <= wait_nxt;
    end
  end

  `HTL_ASSERT_ALWAYS(a_drives_exclusive, !(heater_r && cooler_r), "heater and cooler both driven")
  `HTL_ASSERT_IMPLY(a_fault_off, s1_valid_r && s1_info_r.state == htl_pkg::ST_FAULT, !s1_info_r.heater && !s1_info_r.cooler, "fault item with a drive on")
  `HTL_ASSERT_IMPLY(a_drive_match, s1_valid_r, s1_info_r.heater == heater_r && s1_info_r.cooler == cooler_r, "reported drives differ from drive state")

endmodule

// File: rtl/core/htl_secs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermostat remaining-seconds divider
// Divides the lock time still to run by the tick rate with a registered
// reciprocal multiply, and flags values that saturate the seconds field.
// ----------------------------------------------------------------------------
module htl_secs #(
  parameter int unsigned MS_PER_SECOND = htl_pkg::MS_PER_SECOND_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  output logic                          s1_ready,
  input  htl_pkg::step_info_t           s1_info,
  input  logic [htl_pkg::WAIT_W-1:0]    s1_wait,
  output logic                          s2_valid,
  input  logic                          s2_ready,
  output htl_pkg::step_info_t           s2_info,
  output logic                          s2_sat,
  output logic [htl_pkg::REM_W-1:0]     s2_quot
);

  localparam int unsigned L_BITS = $clog2(MS_PER_SECOND);
  localparam int unsigned SHIFT  = htl_pkg::WAIT_W + L_BITS;
  localparam int unsigned PROD_W = 2 * htl_pkg::WAIT_W + 1;
  // Rounded-up reciprocal: exact floor division for every 31-bit dividend.
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(MS_PER_SECOND) - 64'd1) / 64'(MS_PER_SECOND);
  localparam logic [htl_pkg::WAIT_W:0] RECIP = RECIP_WIDE[htl_pkg::WAIT_W:0];
  // Below this many milliseconds less one the quotient fits 65534.
  localparam logic [47:0] SAT_MS = 48'(MS_PER_SECOND) * 48'd65535;

  logic                     s2_valid_r, s2_valid_nxt;
  htl_pkg::step_info_t      info_r;
  logic                     sat_r, sat_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [PROD_W-1:0]        quot_full;
  logic                     en;

  assign en           = !s2_valid_r || s2_ready;
  assign s1_ready     = en;
  assign s2_valid_nxt = en ? s1_valid : s2_valid_r;

  assign prod_nxt  = PROD_W'(s1_wait) * PROD_W'(RECIP);
  assign sat_nxt   = (48'(s1_wait) >= SAT_MS);
  assign quot_full = prod_r >> SHIFT;

  assign s2_valid = s2_valid_r;
  assign s2_info  = info_r;
  assign s2_sat   = sat_r;
  assign s2_quot  = quot_full[htl_pkg::REM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      info_r <= s1_info;
      sat_r  <= sat_nxt;
      prod_r <= prod_nxt;
    end
  end

endmodule

// File: rtl/core/htl_report.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermostat result stage
// Rounds the remaining lock time up to whole seconds, works out the change
// flag against the previous result and holds the result item for output.
// ----------------------------------------------------------------------------
`include "heat_cool_thermostat_lockout_assert.svh"

module htl_report (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s2_valid,
  output logic                          s2_ready,
  input  htl_pkg::step_info_t           s2_info,
  input  logic                          s2_sat,
  input  logic [htl_pkg::REM_W-1:0]     s2_quot,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [htl_pkg::OUT_W-1:0]     out_tdata
);

  logic                          out_valid_r, out_valid_nxt;
  htl_pkg::out_item_t            out_item_r, out_item_nxt;
  htl_pkg::state_code_t          last_state_r;
  htl_pkg::cause_t               last_cause_r;
  logic [htl_pkg::REM_W-1:0]     last_rem_r;
  logic [htl_pkg::REM_W-1:0]     rem;
  logic                          en, load;

  assign en            = !out_valid_r || out_tready;
  assign load          = en && s2_valid;
  assign s2_ready      = en;
  assign out_valid_nxt = en ? s2_valid : out_valid_r;

  always_comb begin
    if (!s2_info.rem_vld) begin
      rem = '0;
    end else if (s2_sat) begin
      rem = '1;
    end else begin
      rem = s2_quot + htl_pkg::REM_W'(1);
    end

    out_item_nxt                  = '0;
    out_item_nxt.state_code       = s2_info.state;
    out_item_nxt.idle_cause       = s2_info.cause;
    out_item_nxt.heater_on        = s2_info.heater;
    out_item_nxt.cooler_on        = s2_info.cooler;
    out_item_nxt.heating_demand   = s2_info.heat_dem;
    out_item_nxt.cooling_demand   = s2_info.cool_dem;
    out_item_nxt.auto_active      = s2_info.auto_act;
    out_item_nxt.lock_remaining_s = rem;
    out_item_nxt.changed          = s2_info.drive_chg || (s2_info.state != last_state_r) ||
                                    (s2_info.cause != last_cause_r) || (rem != last_rem_r);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      last_state_r <= htl_pkg::ST_IDLE;
      last_cause_r <= htl_pkg::CAUSE_RESET;
      last_rem_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load) begin
        last_state_r <= s2_info.state;
        last_cause_r <= s2_info.cause;
        last_rem_r   <= rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= out_item_nxt;
    end
  end

  `HTL_ASSERT_IMPLY(a_rem_only_locked, out_valid_r && out_item_r.lock_remaining_s != '0, out_item_r.state_code == htl_pkg::ST_LOCK_HEAT || out_item_r.state_code == htl_pkg::ST_LOCK_COOL, "remaining seconds outside a lock state")

endmodule
